/* rtl/ndcg_pkg.sv */
// Shared types, constants and lookup functions for the NDCG block.
package ndcg_pkg;

  typedef enum logic [2:0] {
    CFG_CUTOFF_FIRST  = 3'd0,
    CFG_CUTOFF_SECOND = 3'd1,
    CFG_CUTOFF_THIRD  = 3'd2,
    CFG_CUTOFF_FOURTH = 3'd3
  } cfg_index_t;

  localparam logic [3:0]  CUTOFF_FIRST_RST  = 4'd1;
  localparam logic [3:0]  CUTOFF_SECOND_RST = 4'd3;
  localparam logic [3:0]  CUTOFF_THIRD_RST  = 4'd5;
  localparam logic [3:0]  CUTOFF_FOURTH_RST = 4'd10;
  localparam logic [15:0] NDCG_ONE          = 16'd32768;
  localparam logic [15:0] COUNT_MAX         = 16'hFFFF;

  typedef struct packed {
    logic busy;
    logic finish;
  } seq_status_t;

  // gain 2^g - 1
  function automatic logic [15:0] gain(input logic [3:0] g);
    gain = (16'd1 << g) - 16'd1;
  endfunction

  // round(65536 / log2(2 + r)), Q16
  function automatic logic [16:0] disc(input logic [5:0] r);
    case (r[4:0])
      5'd0:  disc = 17'd65536;
      5'd1:  disc = 17'd41349;
      5'd2:  disc = 17'd32768;
      5'd3:  disc = 17'd28225;
      5'd4:  disc = 17'd25353;
      5'd5:  disc = 17'd23344;
      5'd6:  disc = 17'd21845;
      5'd7:  disc = 17'd20674;
      5'd8:  disc = 17'd19728;
      5'd9:  disc = 17'd18944;
      5'd10: disc = 17'd18281;
      5'd11: disc = 17'd17710;
      5'd12: disc = 17'd17213;
      5'd13: disc = 17'd16774;
      5'd14: disc = 17'd16384;
      5'd15: disc = 17'd16033;
      5'd16: disc = 17'd15716;
      5'd17: disc = 17'd15428;
      5'd18: disc = 17'd15164;
      5'd19: disc = 17'd14921;
      5'd20: disc = 17'd14696;
      5'd21: disc = 17'd14488;
      5'd22: disc = 17'd14294;
      5'd23: disc = 17'd14112;
      5'd24: disc = 17'd13943;
      5'd25: disc = 17'd13783;
      5'd26: disc = 17'd13632;
      5'd27: disc = 17'd13490;
      5'd28: disc = 17'd13356;
      5'd29: disc = 17'd13228;
      5'd30: disc = 17'd13107;
      default: disc = 17'd12992;
    endcase
  endfunction

endpackage

/* rtl/ndcg_chain.sv */
// Sorted insertion chains: top scores with their grades, and top grades.
module ndcg_chain #(
  parameter int TOP_K = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           insert,
  input  logic                           clear,
  input  logic [3:0]                     grade,
  input  logic [15:0]                    score,
  output logic [$clog2(TOP_K+1)-1:0]     fill,
  output logic [3:0]                     ranked_grades [TOP_K],
  output logic [3:0]                     ideal_grades [TOP_K]
);

  localparam int FILLW = $clog2(TOP_K + 1);

  logic [15:0] ranked_scores [TOP_K];
  logic [TOP_K-1:0] score_ge;
  logic [TOP_K-1:0] grade_ge;

  always_comb begin
    for (int i = 0; i < TOP_K; i++) begin
      score_ge[i] = (FILLW'(i) < fill) && (ranked_scores[i] >= score);
      grade_ge[i] = (FILLW'(i) < fill) && (ideal_grades[i] >= grade);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (clear) begin
      fill <= '0;
    end else if (insert) begin
      if (fill < FILLW'(TOP_K)) fill <= fill + FILLW'(1);
    end
  end

  // each cell keeps, takes the new entry, or takes its upper neighbour
  always_ff @(posedge clk) begin
    if (insert) begin
      for (int i = 0; i < TOP_K; i++) begin
        if (!score_ge[i]) begin
          if (i == 0 || score_ge[(i == 0) ? 0 : i-1]) begin
            ranked_scores[i] <= score;
            ranked_grades[i] <= grade;
          end else begin
            ranked_scores[i] <= ranked_scores[(i == 0) ? 0 : i-1];
            ranked_grades[i] <= ranked_grades[(i == 0) ? 0 : i-1];
          end
        end
        if (!grade_ge[i]) begin
          if (i == 0 || grade_ge[(i == 0) ? 0 : i-1]) begin
            ideal_grades[i] <= grade;
          end else begin
            ideal_grades[i] <= ideal_grades[(i == 0) ? 0 : i-1];
          end
        end
      end
    end
  end

endmodule

/* rtl/ndcg_seq.sv */
// Sequencer: DCG sums on a shared multiplier, then restoring division per cutoff.
module ndcg_seq #(
  parameter int TOP_K = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        out_free,
  input  logic [3:0]                  cutoff [4],
  input  logic [$clog2(TOP_K+1)-1:0]  fill,
  input  logic [3:0]                  ranked_grades [TOP_K],
  input  logic [3:0]                  ideal_grades [TOP_K],
  output ndcg_pkg::seq_status_t       status,
  output logic [15:0]                 ndcg [4]
);

  localparam int FILLW = $clog2(TOP_K + 1);
  localparam int IDXW  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int CW    = (FILLW > 4) ? FILLW : 4;
  localparam int SW    = $clog2(TOP_K) + 34;
  localparam int NW    = SW + 16;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MULR = 6'b000010,
    S_MULI = 6'b000100,
    S_DIVI = 6'b001000,
    S_DIVS = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t          state;
  logic [FILLW-1:0] r;
  logic [SW-1:0]   dcg, idcg, dvs, rem;
  logic [SW-1:0]   dcg_s [4];
  logic [SW-1:0]   idcg_s [4];
  logic [16:0]     numlo, quo;
  logic [4:0]      step;
  logic [1:0]      j;
  logic [CW-1:0]   n [4];
  logic [3:0]      g_sel;
  logic [32:0]     prod;
  logic [SW-1:0]   idcg_next;
  logic [NW-1:0]   num_w;
  logic [SW:0]     t;
  logic            qbit;
  logic [16:0]     quo_next;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      n[k] = (CW'(cutoff[k]) < CW'(fill)) ? CW'(cutoff[k]) : CW'(fill);
    end
    g_sel = (state == S_MULR) ? ranked_grades[r[IDXW-1:0]] : ideal_grades[r[IDXW-1:0]];
    prod = {17'd0, ndcg_pkg::gain(g_sel)} * {16'd0, ndcg_pkg::disc(6'(r))};
    idcg_next = idcg + SW'(prod);
    num_w = {1'b0, dcg_s[j], 15'd0} + NW'(idcg_s[j] >> 1);
    t = {rem, numlo[16]};
    qbit = (t >= {1'b0, dvs});
    quo_next = {quo[15:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            r     <= '0;
            dcg   <= '0;
            idcg  <= '0;
            for (int k = 0; k < 4; k++) begin
              dcg_s[k]  <= '0;
              idcg_s[k] <= '0;
            end
            state <= S_MULR;
          end
        end
        S_MULR: begin
          if (r == fill) begin
            j     <= '0;
            state <= S_DIVI;
          end else begin
            dcg   <= dcg + SW'(prod);
            state <= S_MULI;
          end
        end
        S_MULI: begin
          idcg <= idcg_next;
          for (int k = 0; k < 4; k++) begin
            if (n[k] == CW'(r) + CW'(1)) begin
              dcg_s[k]  <= dcg;
              idcg_s[k] <= idcg_next;
            end
          end
          r     <= r + FILLW'(1);
          state <= S_MULR;
        end
        S_DIVI: begin
          dvs   <= idcg_s[j];
          rem   <= SW'(num_w[NW-1:17]);
          numlo <= num_w[16:0];
          quo   <= '0;
          step  <= '0;
          if (idcg_s[j] == '0) begin
            ndcg[j] <= ndcg_pkg::NDCG_ONE;
            if (j == 2'd3) state <= S_DONE;
            else j <= j + 2'd1;
          end else begin
            state <= S_DIVS;
          end
        end
        S_DIVS: begin
          rem   <= qbit ? SW'(t - {1'b0, dvs}) : t[SW-1:0];
          numlo <= {numlo[15:0], 1'b0};
          quo   <= quo_next;
          step  <= step + 5'd1;
          if (step == 5'd16) begin
            ndcg[j] <= (quo_next > 17'(ndcg_pkg::NDCG_ONE)) ? ndcg_pkg::NDCG_ONE
                                                            : quo_next[15:0];
            if (j == 2'd3) begin
              state <= S_DONE;
            end else begin
              j     <= j + 2'd1;
              state <= S_DIVI;
            end
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status.busy   = (state != S_IDLE);
  assign status.finish = (state == S_DONE) && out_free;

endmodule

/* rtl/ndcg_at_cutoffs.sv */
// Top level: NDCG at four rank cutoffs over one query's documents.
// Query tail: a last document starts the sequencer, which goes rank by rank (ranked
//   gain, then ideal gain) over the documents held (fill, up to TOP_K), then divides per
//   cutoff, skipping the division for a cutoff whose ideal sum is zero; an output stall holds it.
// Throughput: one document per cycle inside a query; the shared multiplier and the
//   bit-serial divider (17 steps per cutoff) set the query tail.
// Reset: synchronous, active high; clears chains, count, sequencer and output valid,
//   and sets the cutoffs to 1, 3, 5 and 10.
module ndcg_at_cutoffs #(
  parameter int TOP_K = 10
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  // document channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  relevance,
  input  logic [15:0] predicted_score,
  input  logic        last_of_query,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] ndcg_first,
  output logic [15:0] ndcg_second,
  output logic [15:0] ndcg_third,
  output logic [15:0] ndcg_fourth,
  output logic [15:0] documents_seen
);

  localparam int FILLW = $clog2(TOP_K + 1);

  logic [3:0]  cutoff [4];
  logic [15:0] document_count;
  logic [FILLW-1:0] fill;
  logic [3:0]  ranked_grades [TOP_K];
  logic [3:0]  ideal_grades [TOP_K];
  logic [15:0] ndcg [4];
  ndcg_pkg::seq_status_t status;
  logic        in_take;
  logic        out_free;

  // one query's tail blocks further documents until the sequencer is idle
  assign in_stall = status.busy;
  assign in_take  = in_valid && !in_stall;
  // result register may be overwritten once empty or being taken
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff[0] <= ndcg_pkg::CUTOFF_FIRST_RST;
      cutoff[1] <= ndcg_pkg::CUTOFF_SECOND_RST;
      cutoff[2] <= ndcg_pkg::CUTOFF_THIRD_RST;
      cutoff[3] <= ndcg_pkg::CUTOFF_FOURTH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        ndcg_pkg::CFG_CUTOFF_FIRST:  cutoff[0] <= cfg_data;
        ndcg_pkg::CFG_CUTOFF_SECOND: cutoff[1] <= cfg_data;
        ndcg_pkg::CFG_CUTOFF_THIRD:  cutoff[2] <= cfg_data;
        ndcg_pkg::CFG_CUTOFF_FOURTH: cutoff[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturating document count, cleared once the query's transaction is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      document_count <= '0;
    end else if (status.finish) begin
      document_count <= '0;
    end else if (in_take && document_count != ndcg_pkg::COUNT_MAX) begin
      document_count <= document_count + 16'd1;
    end
  end

  ndcg_chain #(.TOP_K(TOP_K)) u_chain (
    .clk           (clk),
    .rst           (rst),
    .insert        (in_take),
    .clear         (status.finish),
    .grade         (relevance),
    .score         (predicted_score),
    .fill          (fill),
    .ranked_grades (ranked_grades),
    .ideal_grades  (ideal_grades)
  );

  ndcg_seq #(.TOP_K(TOP_K)) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (in_take && last_of_query),
    .out_free      (out_free),
    .cutoff        (cutoff),
    .fill          (fill),
    .ranked_grades (ranked_grades),
    .ideal_grades  (ideal_grades),
    .status        (status),
    .ndcg          (ndcg)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.finish) begin
      ndcg_first     <= ndcg[0];
      ndcg_second    <= ndcg[1];
      ndcg_third     <= ndcg[2];
      ndcg_fourth    <= ndcg[3];
      documents_seen <= document_count;
    end
  end

endmodule

/* rtl/ndcg_checker.sv */
// Port-level checker for the NDCG block, bound to the top level.
module ndcg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        last_of_query,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] ndcg_first,
  input logic [15:0] ndcg_fourth,
  input logic [15:0] documents_seen
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ndcg_first))
    else $error("stalled transaction changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ndcg_first <= 16'd32768) && (ndcg_fourth <= 16'd32768))
    else $error("ndcg above one");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> documents_seen != 16'd0)
    else $error("empty query reported");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_of_query |=> in_stall)
    else $error("last document did not start the query tail");

endmodule

bind ndcg_at_cutoffs ndcg_checker u_ndcg_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .last_of_query  (last_of_query),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .ndcg_first     (ndcg_first),
  .ndcg_fourth    (ndcg_fourth),
  .documents_seen (documents_seen)
);

/* tb/ndcg_at_cutoffs_tb.sv */
// Self-checking testbench for the NDCG-at-four-cutoffs block.
module ndcg_at_cutoffs_tb;

  localparam int TOP_K     = 10;
  localparam int CYCLE_CAP = 1000000;

  // Q16 discount per rank, round(65536 / log2(2 + r))
  localparam int unsigned RANK_DISCOUNT [TOP_K] = '{
    65536, 41349, 32768, 28225, 25353, 23344, 21845, 20674, 19728, 18944
  };

  typedef struct packed {
    logic [15:0] ndcg_first;
    logic [15:0] ndcg_second;
    logic [15:0] ndcg_third;
    logic [15:0] ndcg_fourth;
    logic [15:0] documents_seen;
  } query_score_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [3:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  relevance;
  logic [15:0] predicted_score;
  logic        last_of_query;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] ndcg_first;
  logic [15:0] ndcg_second;
  logic [15:0] ndcg_third;
  logic [15:0] ndcg_fourth;
  logic [15:0] documents_seen;

  ndcg_at_cutoffs #(.TOP_K(TOP_K)) DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .relevance(relevance), .predicted_score(predicted_score),
    .last_of_query(last_of_query),
    .out_valid(out_valid), .out_stall(out_stall),
    .ndcg_first(ndcg_first), .ndcg_second(ndcg_second),
    .ndcg_third(ndcg_third), .ndcg_fourth(ndcg_fourth),
    .documents_seen(documents_seen)
  );

  // Mirror of the block's state: both chains, fill level, count, cutoffs.
  logic [15:0] score_chain [TOP_K];
  logic [3:0]  score_chain_grade [TOP_K];
  logic [3:0]  ideal_chain [TOP_K];
  int unsigned chain_fill;
  int unsigned doc_count;
  logic [3:0]  cutoffs [4];

  query_score_t pending_scores [$];
  bit           mismatch_seen;
  int unsigned  cycle_count;
  int unsigned  results_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit: documents wait on each query tail and the receiver's stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver stall pattern: long quiet stretches, then heavy or light stalling.
  int unsigned stall_mode;
  always @(negedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic void clear_query();
    for (int i = 0; i < TOP_K; i++) begin
      score_chain[i]       = '0;
      score_chain_grade[i] = '0;
      ideal_chain[i]       = '0;
    end
    chain_fill = 0;
    doc_count  = 0;
  endfunction

  // Insert into both chains; an equal score keeps the earlier document ahead.
  function automatic void insert_document(logic [3:0] grade, logic [15:0] score);
    int unsigned p;
    int unsigned q;
    int unsigned tail;
    p = 0;
    q = 0;
    tail = (chain_fill < TOP_K) ? chain_fill : TOP_K - 1;
    while (p < chain_fill && score_chain[p] >= score) p++;
    if (p < TOP_K) begin
      for (int i = tail; i > p; i--) begin
        score_chain[i]       = score_chain[i-1];
        score_chain_grade[i] = score_chain_grade[i-1];
      end
      score_chain[p]       = score;
      score_chain_grade[p] = grade;
    end
    while (q < chain_fill && ideal_chain[q] >= grade) q++;
    if (q < TOP_K) begin
      for (int i = tail; i > q; i--) ideal_chain[i] = ideal_chain[i-1];
      ideal_chain[q] = grade;
    end
    if (chain_fill < TOP_K) chain_fill++;
  endfunction

  function automatic logic [15:0] ndcg_for_cutoff(logic [3:0] k);
    longint unsigned dcg;
    longint unsigned idcg;
    longint unsigned ratio;
    int unsigned     ranks;
    dcg   = 0;
    idcg  = 0;
    ranks = (k < chain_fill) ? k : chain_fill;
    for (int r = 0; r < ranks; r++) begin
      dcg  += ((64'd1 << score_chain_grade[r]) - 1) * RANK_DISCOUNT[r];
      idcg += ((64'd1 << ideal_chain[r]) - 1) * RANK_DISCOUNT[r];
    end
    if (idcg == 0) return ndcg_pkg::NDCG_ONE;
    ratio = (dcg * 32768 + idcg / 2) / idcg;
    return (ratio > 32768) ? ndcg_pkg::NDCG_ONE : ratio[15:0];
  endfunction

  // Expected transactions wait at the back of the queue.
  function automatic void queue_expected(query_score_t s);
    pending_scores.insert(pending_scores.size(), s);
  endfunction

  // Advance the mirror by one document; queue the query's scores on its last one.
  function automatic void predict_document(logic [3:0] grade, logic [15:0] score,
                                           logic last);
    query_score_t s;
    insert_document(grade, score);
    if (doc_count < 65535) doc_count++;
    if (last) begin
      s.ndcg_first     = ndcg_for_cutoff(cutoffs[0]);
      s.ndcg_second    = ndcg_for_cutoff(cutoffs[1]);
      s.ndcg_third     = ndcg_for_cutoff(cutoffs[2]);
      s.ndcg_fourth    = ndcg_for_cutoff(cutoffs[3]);
      s.documents_seen = doc_count[15:0];
      queue_expected(s);
      clear_query();
    end
  endfunction

  task automatic report_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      mismatch_seen = 1'b1;
    end
  endtask

  // Result checker: each accepted transaction against the oldest expectation.
  always @(posedge clk) begin
    query_score_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0d/%0d/%0d/%0d count %0d",
                 $time, ndcg_first, ndcg_second, ndcg_third, ndcg_fourth,
                 documents_seen);
        mismatch_seen = 1'b1;
      end else begin
        want = pending_scores.pop_front();
        report_field("ndcg_first",     want.ndcg_first,     ndcg_first);
        report_field("ndcg_second",    want.ndcg_second,    ndcg_second);
        report_field("ndcg_third",     want.ndcg_third,     ndcg_third);
        report_field("ndcg_fourth",    want.ndcg_fourth,    ndcg_fourth);
        report_field("documents_seen", want.documents_seen, documents_seen);
      end
    end
  end

  // Sender burst state: a gap of random length follows each burst.
  int unsigned burst_left;

  // Present one document and hold it until accepted; prediction follows acceptance.
  // Valid stays high into the next document of a burst and drops only for a gap or a drain.
  task automatic send_document(logic [3:0] grade, logic [15:0] score, logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid        <= 1'b1;
    relevance       <= grade;
    predicted_score <= score;
    last_of_query   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_document(grade, score, last);
    @(negedge clk);
  endtask

  // Stop sending, wait until every query result is in, then let the tail drain.
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_scores.size() != 0) @(negedge clk);
    repeat (2 * TOP_K + 4 * 19 + 20) @(negedge clk);
  endtask

  // Write enable stays high across back-to-back writes; set_cutoffs drops it.
  task automatic write_cutoff(ndcg_pkg::cfg_index_t idx, logic [3:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cutoffs[idx] = value;
    @(negedge clk);
  endtask

  task automatic set_cutoffs(logic [3:0] a, logic [3:0] b, logic [3:0] c, logic [3:0] d);
    write_cutoff(ndcg_pkg::CFG_CUTOFF_FIRST, a);
    write_cutoff(ndcg_pkg::CFG_CUTOFF_SECOND, b);
    write_cutoff(ndcg_pkg::CFG_CUTOFF_THIRD, c);
    write_cutoff(ndcg_pkg::CFG_CUTOFF_FOURTH, d);
    cfg_write <= 1'b0;
  endtask

  // Field extremes, ties, zero ideal DCG, single-document query, chain overflow.
  task automatic test_directed_queries();
    send_document(4'd0, 16'h0000, 1'b1);
    send_document(4'd15, 16'hFFFF, 1'b1);
    send_document(4'd3, 16'h1000, 1'b0);
    send_document(4'd9, 16'h1000, 1'b0);
    send_document(4'd15, 16'h1000, 1'b1);
    send_document(4'd0, 16'h8000, 1'b0);
    send_document(4'd0, 16'h0001, 1'b1);
    // more than TOP_K documents: later low scores drop, high ones displace
    for (int i = 0; i < 13; i++)
      send_document(4'(i), 16'(16'h0100 * (i % 5)), 1'(i == 12));
    drain();
  endtask

  // Cutoff zero, one, and above the documents held.
  task automatic test_cutoff_settings();
    set_cutoffs(4'd0, 4'd1, 4'd15, 4'd10);
    for (int i = 0; i < 4; i++) send_document(4'(15 - i), 16'(i * 300), 1'(i == 3));
    drain();
    set_cutoffs(4'd10, 4'd2, 4'd7, 4'd1);
  endtask

  task automatic random_query(int unsigned docs);
    logic [15:0] score;
    for (int i = 0; i < docs; i++) begin
      // few distinct scores now and then so ties happen
      score = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3) << 14)
                                          : 16'($urandom);
      send_document(4'($urandom_range(0, 15)), score, 1'(i == docs - 1));
    end
  endtask

  task automatic test_random_queries();
    int unsigned sent;
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      for (int q = 0; q < 35; q++) begin
        int unsigned docs;
        docs = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 6);
        random_query(docs);
        sent += docs;
      end
      drain();
      set_cutoffs(4'($urandom_range(0, 15)), 4'($urandom_range(1, 10)),
                  4'($urandom_range(1, 10)), 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = ndcg_pkg::CFG_CUTOFF_FIRST;
    cfg_data        = '0;
    in_valid        = 1'b0;
    relevance       = '0;
    predicted_score = '0;
    last_of_query   = 1'b0;
    out_stall       = 1'b0;
    mismatch_seen   = 1'b0;
    cycle_count     = 0;
    results_seen    = 0;
    burst_left      = 0;
    cutoffs[0] = ndcg_pkg::CUTOFF_FIRST_RST;
    cutoffs[1] = ndcg_pkg::CUTOFF_SECOND_RST;
    cutoffs[2] = ndcg_pkg::CUTOFF_THIRD_RST;
    cutoffs[3] = ndcg_pkg::CUTOFF_FOURTH_RST;
    clear_query();
    repeat (9) @(negedge clk);
    rst = 1'b0;

    test_directed_queries();
    test_cutoff_settings();
    test_random_queries();

    if (!mismatch_seen && pending_scores.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending_scores.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, pending_scores.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
